/* rtl/core/cmls_pkg.sv */
// cmls_pkg: shared types and constants of the conflict marker line scanner
// holds the per-line state struct, the result struct and the character codes
// no dependencies
package cmls_pkg;

    localparam logic [2:0] RUN_MIN   = 3'd7;
    localparam logic [2:0] LABEL_LEN = 3'd7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_LT    = 3'd1;
    localparam logic [2:0] KIND_GT    = 3'd2;
    localparam logic [2:0] KIND_BAR   = 3'd3;
    localparam logic [2:0] KIND_EQ    = 3'd4;
    localparam logic [2:0] KIND_PLUS  = 3'd5;
    localparam logic [2:0] KIND_MINUS = 3'd6;
    localparam logic [2:0] KIND_OTHER = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] run_len;
        logic       in_run;
        logic [2:0] label_len;
        logic       label_ok;
        logic       held_cr;
        logic       any_marker;
    } t_line_state;

    typedef struct packed {
        logic line_done;
        logic line_is_marker;
        logic file_has_marker;
        logic file_done;
    } t_result;

    localparam t_line_state LINE_RESET = '{
        kind:       KIND_NONE,
        run_len:    3'd0,
        in_run:     1'b0,
        label_len:  3'd0,
        label_ok:   1'b1,
        held_cr:    1'b0,
        any_marker: 1'b0
    };

endpackage

/* rtl/core/cmls_line_eval.sv */
// cmls_line_eval: next-state and result logic for one byte of the scanner
// covers held return, leading run, label check and line judgment
// depends on cmls_pkg
module cmls_line_eval (
    input  cmls_pkg::t_line_state i_state,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output cmls_pkg::t_line_state o_state,
    output cmls_pkg::t_result     o_result
);

    function automatic logic [2:0] kind_of(logic [7:0] c);
        case (c)
            cmls_pkg::CH_LT:    return cmls_pkg::KIND_LT;
            cmls_pkg::CH_GT:    return cmls_pkg::KIND_GT;
            cmls_pkg::CH_BAR:   return cmls_pkg::KIND_BAR;
            cmls_pkg::CH_EQ:    return cmls_pkg::KIND_EQ;
            cmls_pkg::CH_PLUS:  return cmls_pkg::KIND_PLUS;
            cmls_pkg::CH_MINUS: return cmls_pkg::KIND_MINUS;
            default:            return cmls_pkg::KIND_OTHER;
        endcase
    endfunction

    // expected label text after a + or - run
    function automatic logic [7:0] label_ref(logic is_base, logic [2:0] i);
        case (i)
            3'd0:    return 8'h20;                   // space
            3'd1:    return is_base ? 8'h42 : 8'h53; // B / S
            3'd2:    return is_base ? 8'h61 : 8'h69; // a / i
            3'd3:    return is_base ? 8'h73 : 8'h64; // s / d
            3'd4:    return 8'h65;                   // e
            3'd5:    return 8'h20;                   // space
            3'd6:    return 8'h23;                   // #
            default: return 8'h00;
        endcase
    endfunction

    function automatic cmls_pkg::t_line_state label_char(cmls_pkg::t_line_state s,
                                                         logic [7:0] c);
        cmls_pkg::t_line_state r;
        r = s;
        case (s.kind)
            cmls_pkg::KIND_LT, cmls_pkg::KIND_GT, cmls_pkg::KIND_BAR: begin
                if (s.label_len == 3'd0 && c != cmls_pkg::CH_SPACE) r.label_ok = 1'b0;
            end
            cmls_pkg::KIND_PLUS, cmls_pkg::KIND_MINUS: begin
                if (s.label_len < cmls_pkg::LABEL_LEN &&
                    c != label_ref(s.kind == cmls_pkg::KIND_MINUS, s.label_len))
                    r.label_ok = 1'b0;
            end
            default: begin
                r.label_ok = 1'b0;
            end
        endcase
        if (s.label_len < cmls_pkg::LABEL_LEN) r.label_len = s.label_len + 3'd1;
        return r;
    endfunction

    function automatic cmls_pkg::t_line_state content_char(cmls_pkg::t_line_state s,
                                                           logic [7:0] c);
        cmls_pkg::t_line_state r;
        logic [2:0]            k;
        r = s;
        k = kind_of(c);
        if (s.kind == cmls_pkg::KIND_NONE) begin
            r.kind    = k;
            r.run_len = 3'd1;
            r.in_run  = 1'b1;
        end else if (s.in_run && k == s.kind && s.kind != cmls_pkg::KIND_OTHER) begin
            if (s.run_len < cmls_pkg::RUN_MIN) r.run_len = s.run_len + 3'd1;
        end else if (s.in_run && s.kind == cmls_pkg::KIND_OTHER) begin
            r.in_run   = 1'b0;
            r.label_ok = 1'b0;
        end else begin
            if (s.in_run) begin
                r.in_run = 1'b0;
                if (s.run_len < cmls_pkg::RUN_MIN) r.label_ok = 1'b0;
            end
            r = label_char(r, c);
        end
        return r;
    endfunction

    function automatic logic judge_line(cmls_pkg::t_line_state s);
        if (s.kind == cmls_pkg::KIND_NONE || s.kind == cmls_pkg::KIND_OTHER) return 1'b0;
        if (s.run_len < cmls_pkg::RUN_MIN || !s.label_ok) return 1'b0;
        if (s.kind == cmls_pkg::KIND_PLUS || s.kind == cmls_pkg::KIND_MINUS)
            return !s.in_run && s.label_len >= cmls_pkg::LABEL_LEN;
        return 1'b1;
    endfunction

    always_comb begin
        cmls_pkg::t_line_state s;
        logic                  done;
        logic                  marker;
        s      = i_state;
        done   = 1'b0;
        marker = 1'b0;

        // a held return that is not followed by newline is line content
        if (s.held_cr) begin
            s.held_cr = 1'b0;
            if (i_byte != cmls_pkg::CH_LF) s = content_char(s, cmls_pkg::CH_CR);
        end

        if (i_byte == cmls_pkg::CH_LF) begin
            done = 1'b1;
        end else if (i_byte == cmls_pkg::CH_CR) begin
            s.held_cr = 1'b1;
        end else begin
            s = content_char(s, i_byte);
        end

        if (i_last) done = 1'b1;

        if (done) begin
            marker = judge_line(s);
            if (marker) s.any_marker = 1'b1;
        end

        o_result.line_done       = done;
        o_result.line_is_marker  = marker;
        o_result.file_has_marker = s.any_marker;
        o_result.file_done       = i_last;

        if (done) begin
            s.kind      = cmls_pkg::LINE_RESET.kind;
            s.run_len   = cmls_pkg::LINE_RESET.run_len;
            s.in_run    = cmls_pkg::LINE_RESET.in_run;
            s.label_len = cmls_pkg::LINE_RESET.label_len;
            s.label_ok  = cmls_pkg::LINE_RESET.label_ok;
            s.held_cr   = cmls_pkg::LINE_RESET.held_cr;
        end
        if (i_last) s = cmls_pkg::LINE_RESET;
        o_state = s;
    end

endmodule

/* rtl/core/conflict_marker_line_scanner.sv */
// conflict_marker_line_scanner: flags conflict marker lines in a byte stream
// depends on cmls_pkg and cmls_line_eval
// each byte passes through the input register, then the result register
// throughput: one byte per cycle while the result channel is not stalled,
// set by the single line-state update per byte
// reset: synchronous active-low i_rst_n empties both registers and clears state
module conflict_marker_line_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_last_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_line_done,
    output logic       o_line_is_marker,
    output logic       o_file_has_marker,
    output logic       o_file_done
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // per-line scan state, updated once per byte that moves to the result stage
    cmls_pkg::t_line_state r_state;
    cmls_pkg::t_line_state n_state;

    // result register
    logic              r_out_valid;
    cmls_pkg::t_result r_out;
    cmls_pkg::t_result n_out;

    logic advance;

    // the byte in the input register moves on whenever the result slot is
    // free or being drained this cycle
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
            r_in_last <= i_last_byte;
        end
    end

    cmls_line_eval u_eval (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmls_pkg::LINE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_line_done       = r_out.line_done;
    assign o_line_is_marker  = r_out.line_is_marker;
    assign o_file_has_marker = r_out.file_has_marker;
    assign o_file_done       = r_out.file_done;

    // a marker is only reported on a closed line
    a_marker_closes_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_is_marker |-> o_line_done)
        else $error("marker reported on an open line");

    // a marker line always shows in the sticky file flag
    a_marker_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_is_marker |-> o_file_has_marker)
        else $error("sticky flag missing for marker line");

    // the last byte of a file always closes its line
    a_file_end_closes_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_file_done |-> o_line_done)
        else $error("file end without line close");

    // after the last byte the scan state is back to idle for the next file
    a_file_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_state == cmls_pkg::LINE_RESET)
        else $error("state not cleared after file end");

endmodule
